// ----- src/kslp_pkg.sv -----
// ============================================================================
// kslp_pkg
// Shared types and constants for the key short/long press detector.
// ============================================================================
package kslp_pkg;

    // Keys carried by the pin word, and keys actually scanned
    localparam int PIN_BITS  = 8;
    localparam int NUM_KEYS  = 8;
    localparam int SCAN_KEYS = (NUM_KEYS > PIN_BITS) ? PIN_BITS : NUM_KEYS;

    // Field widths
    localparam int CNT_W      = 16;
    localparam int KEY_CODE_W = 5;
    localparam int M_TDATA_W  = 8;

    // Key code layout: 0 none, key+1 short, LONG_OFFSET+key+1 long
    localparam logic [KEY_CODE_W-1:0] CODE_NONE   = '0;
    localparam int                    LONG_OFFSET = PIN_BITS;

    // Threshold after reset
    localparam logic [CNT_W-1:0] THRESHOLD_RST = 16'd50;

    // Events reported by one key lane for one scan tick
    typedef struct packed {
        logic short_evt;
        logic long_evt;
    } kslp_evt_t;

endpackage

// ----- src/kslp_key_lane.sv -----
// ============================================================================
// kslp_key_lane
// Per-key state: last pressed level and hold counter, with short/long events.
// ============================================================================
module kslp_key_lane
    import kslp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             scan_en,     // one scan tick is processed
    input  logic             pin_n,       // raw level, 0 means pressed
    input  logic [CNT_W-1:0] threshold,
    output kslp_evt_t        evt          // events for the current tick
);

    logic             held_reg, held_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] count_inc;
    logic             pressed;

    // Next state and events
    always_comb begin
        pressed       = ~pin_n;
        count_inc     = count_reg + CNT_W'(1);
        evt.short_evt = pressed & ~held_reg;
        evt.long_evt  = pressed & (count_inc > threshold);
        held_next     = pressed;
        if (!pressed || evt.long_evt) begin
            count_next = '0;
        end else begin
            count_next = count_inc;
        end
    end

    // State registers, advanced once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg  <= 1'b0;
            count_reg <= '0;
        end else if (scan_en) begin
            held_reg  <= held_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- src/key_short_long_press_detector_core.sv -----
// ============================================================================
// key_short_long_press_detector_core
// Scans eight active-low key pins per beat and reports one key code per beat.
// ============================================================================
//
//  Channel | Dir | Beat contents (low bit first)
//  --------+-----+-----------------------------------------------
//  s_      | in  | tdata[7:0] key_pins_n, bit i = key i, 0 pressed
//  m_      | out | tdata[4:0] key_code, tdata[7:5] zero
//  cfg_    | in  | wr_data[15:0] long_press_threshold
//
//  One beat per cycle sustained while m_tready is high; path: input register,
//  then per-key counter/compare and priority pick into the output register.
//  The input register lets one new beat in while a result waits on m_tready.
//  Reset is synchronous (aresetn low): threshold 50, all counters cleared.
//  Stalls on m_tready back up through the input register to s_tready.
// ============================================================================
module key_short_long_press_detector_core
    import kslp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIN_BITS-1:0]  s_tdata,    // [7:0] key_pins_n
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,    // [4:0] key_code, [7:5] zero
    // Configuration
    input  logic                 cfg_wr_en,
    input  logic [CNT_W-1:0]     cfg_wr_data
);

    logic [CNT_W-1:0]      threshold_reg;
    logic                  in_valid_reg;
    logic [PIN_BITS-1:0]   pins_reg;
    logic                  out_valid_reg;
    logic [KEY_CODE_W-1:0] code_reg, code_next;
    logic                  out_ld;
    logic                  in_ld;
    logic                  scan_en;
    kslp_evt_t             evt [SCAN_KEYS];

    // Handshake: output loads when empty or drained, input when it can move
    assign out_ld   = ~out_valid_reg | m_tready;
    assign s_tready = ~in_valid_reg | out_ld;
    assign in_ld    = s_tvalid & s_tready;
    assign scan_en  = in_valid_reg & out_ld;

    // Threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
        end else if (cfg_wr_en) begin
            threshold_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ld) begin
            pins_reg <= s_tdata;
        end
    end

    // Per-key lanes
    for (genvar k = 0; k < SCAN_KEYS; k++) begin : g_lane
        kslp_key_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .scan_en   (scan_en),
            .pin_n     (pins_reg[k]),
            .threshold (threshold_reg),
            .evt       (evt[k])
        );
    end

    // Priority pick: highest key wins, long beats its own short
    always_comb begin
        code_next = CODE_NONE;
        for (int k = 0; k < SCAN_KEYS; k++) begin
            if (evt[k].short_evt) begin
                code_next = KEY_CODE_W'(k + 1);
            end
            if (evt[k].long_evt) begin
                code_next = KEY_CODE_W'(LONG_OFFSET + k + 1);
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ld) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (scan_en) begin
            code_reg <= code_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - KEY_CODE_W){1'b0}}, code_reg};

endmodule

// ----- src/kslp_checker.sv -----
// ============================================================================
// kslp_checker
// Port-level checks for the key short/long press detector.
// ============================================================================
module kslp_checker
    import kslp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // No result right after reset
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Key code stays within its legal range, padding zero
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:5] == 3'd0) && (m_tdata[4:0] <= 5'd16))
        else $error("key code out of range");

    // With no result pending the input side is never blocked
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind key_short_long_press_detector_core kslp_checker u_kslp_checker (.*);

// ----- dv/testbench.sv -----
// ============================================================================
// testbench
// Regression for key_short_long_press_detector_core. Scan beats go in on the
// s_ stream and key codes come out on the m_ stream, one code per beat. A
// beat-level predictor of the per-key press state and hold counters works
// out each code when its beat is accepted. A checker compares every result
// beat with the oldest pending code. Directed cases, the threshold extremes
// and random press/hold/release traffic are covered, with random stalls on
// both streams.
// ============================================================================
module testbench;
    import kslp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [PIN_BITS-1:0] ALL_RELEASED = '1;

    // DUT ports
    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [PIN_BITS-1:0]  s_tdata     = ALL_RELEASED;   // [7:0] key_pins_n
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;                      // [4:0] key_code, [7:5] zero
    logic                 cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]     cfg_wr_data = '0;

    // Predictor state: keys seen pressed last tick, hold counters, threshold
    logic [PIN_BITS-1:0] pressed_last;
    logic [CNT_W-1:0]    hold_ticks [PIN_BITS];
    logic [CNT_W-1:0]    long_limit;

    // Key codes still to come out on m_
    logic [KEY_CODE_W-1:0] pending_codes [$];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  tx_idling      = 1'b1;
    bit  rx_idling      = 1'b1;
    int  rx_stall_left  = 0;

    key_short_long_press_detector_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("key_short_long_press_detector_core regression: fail");
            $finish;
        end
    end

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // One scan tick of the detector; returns the key code it reports
    function automatic logic [KEY_CODE_W-1:0] scan_tick(input logic [PIN_BITS-1:0] pins_n);
        logic [KEY_CODE_W-1:0] code;
        logic                  pressed;
        code = CODE_NONE;
        for (int k = 0; k < SCAN_KEYS; k++) begin
            pressed = !pins_n[k];
            // released -> pressed gives a short press
            if (pressed && !pressed_last[k])
                code = KEY_CODE_W'(k + 1);
            pressed_last[k] = pressed;
            if (pressed) begin
                hold_ticks[k] = hold_ticks[k] + CNT_W'(1);
                // long press beats the short press of the same key
                if (hold_ticks[k] > long_limit) begin
                    hold_ticks[k] = '0;
                    code = KEY_CODE_W'(LONG_OFFSET + k + 1);
                end
            end else begin
                hold_ticks[k] = '0;
            end
        end
        return code;
    endfunction

    // Result side backpressure
    always @(posedge aclk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end else if (rx_idling && aresetn && $urandom_range(0, 99) < 25) begin
            rx_stall_left = pick_gap() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge aclk) begin
        logic [KEY_CODE_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_codes.size() == 0) begin
                $error("unexpected result beat: key_code %0d", m_tdata[KEY_CODE_W-1:0]);
                mismatch_count++;
            end else begin
                want = pending_codes.pop_front();
                if (m_tdata[KEY_CODE_W-1:0] !== want) begin
                    $error("key_code: expected %0d, actual %0d",
                           want, m_tdata[KEY_CODE_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[M_TDATA_W-1:KEY_CODE_W] !== '0) begin
                    $error("tdata pad: expected 0, actual %0h",
                           m_tdata[M_TDATA_W-1:KEY_CODE_W]);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one scan beat; the predicted code is queued once it is accepted
    task automatic send_scan(input logic [PIN_BITS-1:0] pins_n);
        if (tx_idling && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            repeat (pick_gap()) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pins_n;
        do @(posedge aclk); while (!s_tready);
        pending_codes.push_back(scan_tick(pins_n));
    endtask

    // Stop sending and let every pending result drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Threshold write, only while the block is idle
    task automatic write_threshold(input logic [CNT_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        long_limit = value;
    endtask

    // Random press/hold/release traffic, with some noise and bounce
    task automatic run_press_mix(input int n_beats, input int max_hold);
        int                  sent;
        int                  hold;
        int                  rel;
        logic [PIN_BITS-1:0] keys;
        sent = 0;
        while (sent < n_beats) begin
            if ($urandom_range(0, 9) == 0) begin
                send_scan(PIN_BITS'($urandom()));
                sent++;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: keys = PIN_BITS'(1) << $urandom_range(0, PIN_BITS - 1);
                    5, 6:          keys = (PIN_BITS'(1) << $urandom_range(0, PIN_BITS - 1))
                                        | (PIN_BITS'(1) << $urandom_range(0, PIN_BITS - 1));
                    default:       keys = PIN_BITS'($urandom());
                endcase
                hold = $urandom_range(1, max_hold);
                for (int t = 0; t < hold; t++) begin
                    // a one-tick bounce on a random pin
                    if ($urandom_range(0, 19) == 0)
                        send_scan(~keys ^ (PIN_BITS'(1) << $urandom_range(0, PIN_BITS - 1)));
                    else
                        send_scan(~keys);
                end
                rel = $urandom_range(1, 3);
                repeat (rel) send_scan(ALL_RELEASED);
                sent += hold + rel;
            end
        end
    endtask

    // Threshold after reset, holds around 50 ticks
    task automatic test_default_threshold();
        run_press_mix(200, 120);
    endtask

    // Hand-picked beats: extremes, priority, zero threshold, no-long threshold
    task automatic test_directed_cases();
        write_threshold(16'd2);
        send_scan(8'hFF);
        send_scan(8'hFE);   // key 0 short
        send_scan(8'hFE);
        send_scan(8'hFE);   // key 0 long
        send_scan(8'hFE);
        send_scan(8'h7E);   // key 7 short
        send_scan(8'h7E);   // key 0 long
        send_scan(8'h7F);
        send_scan(8'h00);   // several shorts at once
        send_scan(8'h00);
        send_scan(8'h00);   // several longs at once
        send_scan(8'hFF);
        send_scan(8'h55);
        send_scan(8'hAA);
        write_threshold(16'd0);
        send_scan(8'hFE);   // long on first pressed tick
        send_scan(8'hFE);
        send_scan(8'hFF);
        send_scan(8'h00);
        write_threshold(16'hFFFF);
        send_scan(8'h00);
        send_scan(8'h00);
        send_scan(8'hFF);
    endtask

    // Largest firing threshold and the no-long threshold over steady holds
    task automatic test_hold_extremes();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        write_threshold(16'hFFFE);
        repeat (30) send_scan(8'hF7);   // key 3 short, no long this soon
        send_scan(ALL_RELEASED);
        write_threshold(16'hFFFF);
        repeat (30) send_scan(8'hDF);   // key 5 short, never long
        send_scan(ALL_RELEASED);
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    // Random traffic over a spread of thresholds
    task automatic test_random_thresholds();
        logic [CNT_W-1:0] limits [5];
        limits[0] = 16'd0;
        limits[1] = 16'd1;
        limits[2] = 16'd3;
        limits[3] = CNT_W'($urandom_range(2, 12));
        limits[4] = CNT_W'($urandom_range(13, 40));
        foreach (limits[i]) begin
            write_threshold(limits[i]);
            // one phase with no stalls on either side
            tx_idling = (i != 2);
            rx_idling = (i != 2);
            run_press_mix(100, 3 * int'(limits[i]) + 4);
        end
        tx_idling = 1'b1;
        rx_idling = 1'b1;
    endtask

    // Main sequence
    initial begin
        pressed_last = '0;
        foreach (hold_ticks[k]) hold_ticks[k] = '0;
        long_limit = THRESHOLD_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_threshold();
        test_directed_cases();
        test_hold_extremes();
        test_random_thresholds();

        wait_idle();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0)
            $display("key_short_long_press_detector_core regression: pass");
        else
            $display("key_short_long_press_detector_core regression: fail");
        $finish;
    end

endmodule

// ----- key_short_long_press_detector_core.f -----
src/kslp_pkg.sv
src/kslp_key_lane.sv
src/key_short_long_press_detector_core.sv
src/kslp_checker.sv
dv/testbench.sv
